### rtl/signed_header_rle_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the signed header run-length decoder.
// ----------------------------------------------------------------------------
`ifndef SIGNED_HEADER_RLE_DECODER_ASSERT_SVH
`define SIGNED_HEADER_RLE_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRLED_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srled assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SRLED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srled assertion failed");

`endif

### rtl/srled_pkg.sv
// ----------------------------------------------------------------------------
// srled_pkg
// Types and constants shared by the signed header run-length decoder.
// ----------------------------------------------------------------------------
package srled_pkg;

    localparam int OUT_LANES = 4;
    // Lanes actually used, limited to the range 1 to 4.
    localparam int LANES = (OUT_LANES < 1) ? 1 : ((OUT_LANES > 4) ? 4 : OUT_LANES);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte_0;
        logic [7:0] out_byte_1;
        logic [7:0] out_byte_2;
        logic [7:0] out_byte_3;
        logic [2:0] out_count;
        logic       run_last;
    } out_item_t;

    // One command for the back end: emit value len times.
    typedef struct packed {
        logic [7:0] value;
        logic [6:0] len;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } push_t;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_VALUE   = 3'b010,
        PH_LITERAL = 3'b100
    } phase_t;

endpackage

### rtl/srled_front.sv
// ----------------------------------------------------------------------------
// srled_front
// Accepts compressed bytes, parses headers and hands run commands to the queue.
// ----------------------------------------------------------------------------
module srled_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  srled_pkg::in_item_t byte_item,
    input  logic               q_full,
    output srled_pkg::push_t   push
);
    import srled_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] literal_left_reg, literal_left_next;
    logic [6:0] repeat_len_reg, repeat_len_next;
    logic       accept;

    assign byte_ready = !q_full;
    assign accept     = byte_valid && byte_ready;

    always_comb
    begin
        phase_next        = phase_reg;
        literal_left_next = literal_left_reg;
        repeat_len_next   = repeat_len_reg;
        push.valid        = 1'b0;
        push.cmd.value    = byte_item.in_byte;
        push.cmd.len      = 7'd1;
        if (accept)
        begin
            unique case (phase_reg)
                PH_VALUE:
                begin
                    push.valid      = 1'b1;
                    push.cmd.len    = repeat_len_reg;
                    phase_next      = PH_HEADER;
                    repeat_len_next = 7'd0;
                end
                PH_LITERAL:
                begin
                    push.valid        = 1'b1;
                    literal_left_next = literal_left_reg - 8'd1;
                    if (literal_left_next == 8'd0)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                    if (byte_item.in_byte[7])
                    begin
                        // Negative header: 256 minus the header literal bytes follow.
                        literal_left_next = 8'd0 - byte_item.in_byte;
                        phase_next        = PH_LITERAL;
                    end
                    else if (byte_item.in_byte != 8'd0)
                    begin
                        repeat_len_next = byte_item.in_byte[6:0];
                        phase_next      = PH_VALUE;
                    end
                end
            endcase
            if (byte_item.in_last)
            begin
                phase_next        = PH_HEADER;
                literal_left_next = 8'd0;
                repeat_len_next   = 7'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            literal_left_reg <= 8'd0;
            repeat_len_reg   <= 7'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            literal_left_reg <= literal_left_next;
            repeat_len_reg   <= repeat_len_next;
        end
    end

endmodule

### rtl/srled_queue.sv
// ----------------------------------------------------------------------------
// srled_queue
// Short command queue between the parser and the beat generator.
// ----------------------------------------------------------------------------
`include "signed_header_rle_decoder_assert.svh"

module srled_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  srled_pkg::push_t push,
    input  logic             pop,
    output logic             q_full,
    output logic             q_valid,
    output srled_pkg::cmd_t  q_head
);
    import srled_pkg::*;

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign q_full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push.valid && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem[wr_ptr_reg] <= push.cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `SRLED_ASSERT_NOW(a_no_push_when_full, push.valid, !q_full)
    `SRLED_ASSERT_NOW(a_no_pop_when_empty, pop, q_valid)
    `SRLED_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= QCNT_W'(QDEPTH))

endmodule

### rtl/srled_back.sv
// ----------------------------------------------------------------------------
// srled_back
// Expands queued commands into output beats of up to LANES bytes each.
// ----------------------------------------------------------------------------
`include "signed_header_rle_decoder_assert.svh"

module srled_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  srled_pkg::cmd_t      q_head,
    output logic                 pop,
    output logic                 beat_valid,
    input  logic                 beat_ready,
    output srled_pkg::out_item_t beat_item
);
    import srled_pkg::*;

    logic       active_reg, active_next;
    logic [6:0] left_reg, left_next;
    logic       beat_valid_reg, beat_valid_next;
    out_item_t  beat_item_reg, beat_item_next;
    logic [6:0] rem;
    logic [6:0] rem_after;
    logic [2:0] cnt;
    logic       fire;

    // While a run is partly out, the remaining length lives here and the
    // command stays at the head of the queue for its value.
    assign rem       = active_reg ? left_reg : q_head.len;
    assign cnt       = (rem > 7'(LANES)) ? 3'(LANES) : rem[2:0];
    assign rem_after = rem - {4'd0, cnt};
    assign fire      = q_valid && (!beat_valid_reg || beat_ready);
    assign pop       = fire && (rem_after == 7'd0);

    always_comb
    begin
        active_next     = active_reg;
        left_next       = left_reg;
        beat_item_next  = beat_item_reg;
        beat_valid_next = beat_valid_reg && !beat_ready;
        if (fire)
        begin
            active_next               = (rem_after != 7'd0);
            left_next                 = rem_after;
            beat_valid_next           = 1'b1;
            beat_item_next.out_byte_0 = (cnt > 3'd0) ? q_head.value : 8'd0;
            beat_item_next.out_byte_1 = (cnt > 3'd1) ? q_head.value : 8'd0;
            beat_item_next.out_byte_2 = (cnt > 3'd2) ? q_head.value : 8'd0;
            beat_item_next.out_byte_3 = (cnt > 3'd3) ? q_head.value : 8'd0;
            beat_item_next.out_count  = cnt;
            beat_item_next.run_last   = (rem_after == 7'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        beat_item_reg <= beat_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            left_reg       <= 7'd0;
            beat_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            left_reg       <= left_next;
            beat_valid_reg <= beat_valid_next;
        end
    end

    assign beat_valid = beat_valid_reg;
    assign beat_item  = beat_item_reg;

    `SRLED_ASSERT_NOW(a_count_range, beat_valid_reg,
        (beat_item_reg.out_count != 3'd0) && (beat_item_reg.out_count <= 3'(LANES)))
    `SRLED_ASSERT_NOW(a_short_beat_is_last,
        beat_valid_reg && (beat_item_reg.out_count < 3'(LANES)), beat_item_reg.run_last)
    `SRLED_ASSERT_NOW(a_active_has_head, active_reg, q_valid && (left_reg != 7'd0))
    `SRLED_ASSERT_NEXT(a_pop_ends_run, pop, !active_reg)

endmodule

### rtl/signed_header_rle_decoder.sv
// The decoder takes one compressed byte per cycle on the byte channel and
// delivers decoded beats of up to four bytes on the beat channel. Header bytes,
// literal bytes and repeat values all arrive on the byte channel; a literal
// byte gives one beat and a repeat of n bytes gives ceil(n/4) beats, one beat
// per cycle from the beat generator while beat_ready is high. Parsed commands
// wait in a four-entry queue, so the byte channel stalls only when that queue
// is full, which happens when repeat runs arrive faster than their beats drain
// or when the beat channel is held off. There is no start-up delay after reset.
// ----------------------------------------------------------------------------
// signed_header_rle_decoder
// Signed header run-length decoder: parser, command queue and beat generator.
// ----------------------------------------------------------------------------
module signed_header_rle_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  srled_pkg::in_item_t  byte_item,
    output logic                 beat_valid,
    input  logic                 beat_ready,
    output srled_pkg::out_item_t beat_item
);
    import srled_pkg::*;

    push_t push;
    logic  q_full;
    logic  q_valid;
    cmd_t  q_head;
    logic  pop;

    srled_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .q_full     (q_full),
        .push       (push)
    );

    srled_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .pop     (pop),
        .q_full  (q_full),
        .q_valid (q_valid),
        .q_head  (q_head)
    );

    srled_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .pop        (pop),
        .beat_valid (beat_valid),
        .beat_ready (beat_ready),
        .beat_item  (beat_item)
    );

endmodule
